@@ design/lbct_pkg.sv @@
// Shared types and constants for the blink channel table.
// Used by lbct_front, lbct_exec and the top level; depends on nothing.
package lbct_pkg;

  localparam int LBCT_SLOTS = 8;
  localparam int CMD_DEPTH  = 2;
  localparam int RES_DEPTH  = 2;
  localparam int MS_PER_SEC = 1000;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CREATE = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_REMOVE,
    ST_TICK,
    ST_FLUSH
  } exec_state_t;

  // Classified command handed from the front to the engine.
  typedef struct packed {
    action_t     action;
    logic [31:0] now;
    logic [15:0] cadence;
    logic [5:0]  pin;
    logic [31:0] life;
    logic [5:0]  sel;
  } cmd_t;

  // Per-slot record kept in the slot RAM; slot activity lives in flops.
  typedef struct packed {
    logic [5:0]  pin;
    logic [31:0] life;
    logic [31:0] start;
    logic [32:0] deadline;
    logic        level;
    logic [15:0] cadence;
  } slot_rec_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  slot_index;
    logic        accepted;
    logic        drive_pin;
    logic [5:0]  pin_number;
    logic        pin_level;
    logic        last;
  } res_t;

endpackage

@@ design/lbct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbct_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                           rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/lbct_fifo.sv @@
// Small show-ahead FIFO built from flops, used for the command and result queues.
// No dependencies.
module lbct_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/lbct_front.sv @@
// Front end: takes input transfers, drops unused action codes, converts the
// run time to milliseconds and queues commands. Uses lbct_pkg and lbct_fifo.
module lbct_front
  import lbct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [31:0] now_ms,
  input  logic [15:0] cadence_ms,
  input  logic [5:0]  pin_select,
  input  logic [22:0] run_seconds,
  input  logic [5:0]  slot_select,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  logic [32:0] life_prod;
  cmd_t        cmd_in;
  logic        q_push;
  logic        q_empty;
  logic [$bits(cmd_t)-1:0] q_dout;

  // 23 x 10 bit product fits in 33 bits; saturate to 32.
  assign life_prod = {10'd0, run_seconds} * 33'(MS_PER_SEC);

  always_comb begin
    cmd_in.action  = action_t'(action);
    cmd_in.now     = now_ms;
    cmd_in.cadence = cadence_ms;
    cmd_in.pin     = pin_select;
    cmd_in.life    = life_prod[32] ? 32'hFFFF_FFFF : life_prod[31:0];
    cmd_in.sel     = slot_select;
  end

  // Unused code is accepted and dropped here.
  assign q_push = push && (action_t'(action) != ACT_NONE);

  lbct_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd       = cmd_t'(q_dout);

endmodule

@@ design/lbct_exec.sv @@
// Back end: owns the slot table and runs create, remove and tick commands.
// Uses lbct_pkg and lbct_ram.
module lbct_exec
  import lbct_pkg::*;
#(
  parameter int SLOTS = LBCT_SLOTS
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic res_push,
  output res_t res,
  input  logic res_full
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = IW + 1;

  exec_state_t state, state_next;
  cmd_t        cur, cur_next;
  logic [SLOTS-1:0] act, act_next;
  logic [CW-1:0]    rd_ptr, rd_ptr_next;
  logic             ev_valid, ev_valid_next;
  logic [IW-1:0]    ev_idx, ev_idx_next;
  logic             pend_valid, pend_valid_next;
  res_t             pend, pend_next;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_rec_t     ram_wdata;
  logic [IW-1:0] raddr;
  slot_rec_t     rdata;

  // free slot search
  logic          found;
  logic [IW-1:0] free_idx;

  // tick evaluation of the slot at ev_idx
  logic [31:0] elapsed;
  logic        expire;
  logic        toggle;
  logic        emit;
  logic        stall;
  logic        ev_go;
  logic        rd_live;
  res_t        ev_res;
  slot_rec_t   ev_rec;

  // remove
  logic        rm_hit;
  logic [IW-1:0] rm_idx;

  lbct_ram #(
    .W     ($bits(slot_rec_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!act[i]) begin
        found    = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign rm_idx = cur.sel[IW-1:0];
  assign rm_hit = ({1'b0, cur.sel} < 7'(SLOTS)) && act[rm_idx];

  assign elapsed = cur.now - rdata.start;
  assign expire  = (rdata.life != '0) && (elapsed >= rdata.life);
  assign toggle  = !expire && ({1'b0, elapsed} >= rdata.deadline);
  assign emit    = ev_valid && act[ev_idx] && (expire || toggle);
  assign stall   = emit && pend_valid && res_full;
  assign ev_go   = !ev_valid || !stall;
  assign rd_live = (rd_ptr < CW'(SLOTS));

  always_comb begin
    ev_rec          = rdata;
    ev_rec.level    = ~rdata.level;
    ev_rec.deadline = rdata.deadline + {17'd0, rdata.cadence};
    ev_res.kind       = KIND_TICK;
    ev_res.slot_index = 7'(ev_idx);
    ev_res.accepted   = 1'b0;
    ev_res.drive_pin  = 1'b1;
    ev_res.pin_number = rdata.pin;
    ev_res.pin_level  = expire ? 1'b0 : ~rdata.level;
    ev_res.last       = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act        <= '0;
      ev_valid   <= 1'b0;
      pend_valid <= 1'b0;
      rd_ptr     <= '0;
    end else begin
      act        <= act_next;
      ev_valid   <= ev_valid_next;
      pend_valid <= pend_valid_next;
      rd_ptr     <= rd_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    ev_idx <= ev_idx_next;
    pend   <= pend_next;
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    act_next        = act;
    rd_ptr_next     = rd_ptr;
    ev_valid_next   = ev_valid;
    ev_idx_next     = ev_idx;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    res             = '0;
    ram_we          = 1'b0;
    ram_waddr       = ev_idx;
    ram_wdata       = ev_rec;
    raddr           = rm_idx;

    unique case (state)
      ST_IDLE: begin
        raddr = cmd.sel[IW-1:0];
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          cur_next = cmd;
          unique case (cmd.action)
            ACT_CREATE: state_next = ST_CREATE;
            ACT_REMOVE: state_next = ST_REMOVE;
            default: begin
              rd_ptr_next   = '0;
              ev_valid_next = 1'b0;
              state_next    = ST_TICK;
            end
          endcase
        end
      end

      ST_CREATE: begin
        res.kind       = KIND_CREATE;
        res.slot_index = found ? 7'(free_idx) : 7'(SLOTS);
        res.accepted   = found;
        res.last       = 1'b1;
        if (!res_full) begin
          res_push = 1'b1;
          if (found) begin
            ram_we             = 1'b1;
            ram_waddr          = free_idx;
            ram_wdata.pin      = cur.pin;
            ram_wdata.life     = cur.life;
            ram_wdata.start    = cur.now;
            ram_wdata.deadline = '0;
            ram_wdata.level    = 1'b0;
            ram_wdata.cadence  = cur.cadence;
            // zero cadence leaves the slot free
            act_next[free_idx] = (cur.cadence != '0);
          end
          state_next = ST_IDLE;
        end
      end

      ST_REMOVE: begin
        res.kind       = KIND_REMOVE;
        res.slot_index = {1'b0, cur.sel};
        res.accepted   = rm_hit;
        res.drive_pin  = rm_hit;
        res.pin_number = rm_hit ? rdata.pin : 6'd0;
        res.last       = 1'b1;
        if (!res_full) begin
          res_push = 1'b1;
          if (rm_hit) begin
            act_next[rm_idx] = 1'b0;
          end
          state_next = ST_IDLE;
        end
      end

      ST_TICK: begin
        // Read of the next slot overlaps evaluation of the current one;
        // on a stall the read address holds so the RAM output stays aligned.
        raddr = ev_go ? rd_ptr[IW-1:0] : ev_idx;
        if (emit && !stall) begin
          // Results are held back one step so the final one can carry last.
          if (pend_valid) begin
            res_push = 1'b1;
            res      = pend;
          end
          pend_next       = ev_res;
          pend_valid_next = 1'b1;
          if (expire) begin
            act_next[ev_idx] = 1'b0;
          end else begin
            ram_we = 1'b1;
          end
        end
        if (ev_go) begin
          ev_valid_next = rd_live;
          ev_idx_next   = rd_ptr[IW-1:0];
          if (rd_live) begin
            rd_ptr_next = rd_ptr + 1'b1;
          end else begin
            state_next = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        res      = pend;
        res.last = 1'b1;
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (!res_full) begin
          res_push        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ design/led_blink_channel_table.sv @@
// Blink channel table: SLOTS blink channels that toggle output pins on a
// millisecond time base. Input and result sides are queues (push/full,
// empty/pop). A tick walks every slot through the slot RAM, one slot per
// cycle, and is held longer while the result queue is full.
// Commands pass through a 2-entry queue, so the front keeps taking transfers
// while the engine is busy. Depends on lbct_pkg, lbct_front, lbct_exec, lbct_fifo.
module led_blink_channel_table
  import lbct_pkg::*;
#(
  parameter int SLOTS = LBCT_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [31:0] now_ms,
  input  logic [15:0] cadence_ms,
  input  logic [5:0]  pin_select,
  input  logic [22:0] run_seconds,
  input  logic [5:0]  slot_select,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [6:0]  slot_index,
  output logic        accepted,
  output logic        drive_pin,
  output logic [5:0]  pin_number,
  output logic        pin_level,
  output logic        last
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_push;
  res_t res_in;
  logic res_full;
  logic [$bits(res_t)-1:0] res_dout;
  res_t res_head;

  lbct_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .now_ms      (now_ms),
    .cadence_ms  (cadence_ms),
    .pin_select  (pin_select),
    .run_seconds (run_seconds),
    .slot_select (slot_select),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  lbct_exec #(
    .SLOTS (SLOTS)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  lbct_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign res_head   = res_t'(res_dout);
  assign kind       = res_head.kind;
  assign slot_index = res_head.slot_index;
  assign accepted   = res_head.accepted;
  assign drive_pin  = res_head.drive_pin;
  assign pin_number = res_head.pin_number;
  assign pin_level  = res_head.pin_level;
  assign last       = res_head.last;

endmodule

@@ dv/led_blink_channel_table_test.sv @@
// Self-checking testbench for led_blink_channel_table: directed and random
// create/remove/tick traffic, results checked against an in-bench channel model.
// Depends on lbct_pkg and the led_blink_channel_table RTL.
`timescale 1ns / 100ps

module led_blink_channel_table_test;
  import lbct_pkg::*;

  localparam int SLOTS = LBCT_SLOTS;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  action = '0;
  logic [31:0] now_ms = '0;
  logic [15:0] cadence_ms = '0;
  logic [5:0]  pin_select = '0;
  logic [22:0] run_seconds = '0;
  logic [5:0]  slot_select = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [6:0]  slot_index;
  logic        accepted;
  logic        drive_pin;
  logic [5:0]  pin_number;
  logic        pin_level;
  logic        last;

  led_blink_channel_table #(.SLOTS(SLOTS)) u_top (
    .clk, .rst, .push, .full, .action, .now_ms, .cadence_ms, .pin_select,
    .run_seconds, .slot_select, .empty, .pop, .kind, .slot_index, .accepted,
    .drive_pin, .pin_number, .pin_level, .last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Channel table as the block should hold it
  logic [15:0] chan_cadence[SLOTS];
  logic [5:0]  chan_pin[SLOTS];
  logic [31:0] chan_life[SLOTS];
  logic        chan_level[SLOTS];
  logic [31:0] chan_start[SLOTS];
  logic [32:0] chan_deadline[SLOTS];

  res_t        pin_events[$];
  int          errors = 0;
  bit          gaps_on = 1'b1;
  logic [31:0] clock_ms = '0;

  task automatic report_mismatch(string msg);
    $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic void release_channel(int s);
    chan_cadence[s]  = '0;
    chan_pin[s]      = '0;
    chan_life[s]     = '0;
    chan_level[s]    = 1'b0;
    chan_start[s]    = '0;
    chan_deadline[s] = '0;
  endfunction

  function automatic void predict_channel_table(action_t act, logic [31:0] now,
      logic [15:0] cad, logic [5:0] pin, logic [22:0] secs, logic [5:0] sel);
    res_t        ev[$];
    res_t        r;
    int          s;
    logic [63:0] life;
    logic [31:0] elapsed;
    case (act)
      ACT_CREATE: begin
        s = 0;
        while (s < SLOTS && chan_cadence[s] != 0) s++;
        r = '0;
        r.kind = KIND_CREATE;
        r.slot_index = 7'(s);
        if (s < SLOTS) begin
          life = 64'(secs) * 64'd1000;
          if (life > 64'hFFFF_FFFF) life = 64'hFFFF_FFFF;
          chan_level[s]    = 1'b0;
          chan_start[s]    = now;
          chan_deadline[s] = '0;
          chan_cadence[s]  = cad;
          chan_pin[s]      = pin;
          chan_life[s]     = life[31:0];
          r.accepted = 1'b1;
        end
        ev.push_back(r);
      end
      ACT_REMOVE: begin
        r = '0;
        r.kind = KIND_REMOVE;
        r.slot_index = 7'(sel);
        if (sel < SLOTS && chan_cadence[sel] != 0) begin
          r.accepted   = 1'b1;
          r.drive_pin  = 1'b1;
          r.pin_number = chan_pin[sel];
          release_channel(sel);
        end
        ev.push_back(r);
      end
      ACT_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (chan_cadence[i] != 0) begin
            elapsed = now - chan_start[i];
            r = '0;
            r.kind = KIND_TICK;
            r.slot_index = 7'(i);
            r.drive_pin = 1'b1;
            r.pin_number = chan_pin[i];
            if (chan_life[i] != 0 && elapsed >= chan_life[i]) begin
              ev.push_back(r);
              release_channel(i);
            end else if ({1'b0, elapsed} >= chan_deadline[i]) begin
              chan_level[i] = ~chan_level[i];
              r.pin_level = chan_level[i];
              ev.push_back(r);
              chan_deadline[i] = chan_deadline[i] + 33'(chan_cadence[i]);
            end
          end
        end
      end
      default: ;
    endcase
    if (ev.size() > 0) ev[ev.size() - 1].last = 1'b1;
    foreach (ev[i]) pin_events.push_back(ev[i]);
  endfunction

  // One input transfer; push stays high between back-to-back items
  task automatic send_item(action_t act, logic [31:0] now, logic [15:0] cad,
      logic [5:0] pin, logic [22:0] secs, logic [5:0] sel);
    if (gaps_on && $urandom_range(99) < 22) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    action      <= act;
    now_ms      <= now;
    cadence_ms  <= cad;
    pin_select  <= pin;
    run_seconds <= secs;
    slot_select <= sel;
    push        <= 1'b1;
    do @(posedge clk); while (full);
    predict_channel_table(act, now, cad, pin, secs, sel);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pin_events.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= !gaps_on || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && pop && !empty) begin
      if (pin_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d slot %0d", kind, slot_index));
      end else begin
        want = pin_events.pop_front();
        check_field("kind", kind, want.kind);
        check_field("slot_index", slot_index, want.slot_index);
        check_field("accepted", accepted, want.accepted);
        check_field("drive_pin", drive_pin, want.drive_pin);
        check_field("pin_number", pin_number, want.pin_number);
        check_field("pin_level", pin_level, want.pin_level);
        check_field("last", last, want.last);
      end
    end
  end

  // Zero cadence takes no slot; fill the table with extreme fields, then overflow
  task automatic test_create_and_full();
    send_item(ACT_CREATE, 32'd0, 16'd0, 6'd63, 23'd5, 6'd0);
    send_item(ACT_CREATE, 32'd0, 16'd1, 6'd0, 23'd0, 6'd63);
    send_item(ACT_CREATE, 32'd0, 16'hFFFF, 6'd63, 23'h7F_FFFF, 6'd0);
    send_item(ACT_CREATE, 32'd0, 16'd2, 6'd21, 23'd1, 6'd0);
    send_item(ACT_CREATE, 32'd0, 16'd3, 6'd42, 23'd4294967, 6'd0);
    for (int i = 4; i < SLOTS; i++)
      send_item(ACT_CREATE, 32'd0, 16'(i + 1), 6'(i), 23'd0, 6'd0);
    send_item(ACT_CREATE, 32'd0, 16'd7, 6'd9, 23'd0, 6'd0);
  endtask

  task automatic test_remove();
    send_item(ACT_REMOVE, 32'd0, 16'd0, 6'd0, 23'd0, 6'd63);
    send_item(ACT_REMOVE, 32'd0, 16'd0, 6'd0, 23'd0, 6'(SLOTS));
    send_item(ACT_REMOVE, 32'd0, 16'd0, 6'd0, 23'd0, 6'(SLOTS - 1));
    send_item(ACT_REMOVE, 32'd0, 16'd0, 6'd0, 23'd0, 6'(SLOTS - 1));
  endtask

  // First tick toggles all high; short life expires at 1 s; max elapsed time
  // expires the saturated and near-maximum lives; unused action code does nothing
  task automatic test_tick_edges();
    send_item(ACT_TICK, 32'd0, 16'd0, 6'd0, 23'd0, 6'd0);
    send_item(ACT_TICK, 32'd1, 16'd0, 6'd0, 23'd0, 6'd0);
    send_item(ACT_TICK, 32'd1000, 16'd0, 6'd0, 23'd0, 6'd0);
    send_item(ACT_TICK, 32'hFFFF_FFFF, 16'd0, 6'd0, 23'd0, 6'd0);
    send_item(ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, 6'd63, 23'h7F_FFFF, 6'd63);
  endtask

  task automatic run_random_traffic(int count);
    int          sent;
    int          pick;
    int          r;
    logic [15:0] cad;
    logic [22:0] secs;
    logic [5:0]  sel;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      r = $urandom_range(99);
      if (pick < 4) begin
        // noise with an unused action code
        send_item(ACT_NONE, $urandom, 16'($urandom), 6'($urandom), 23'($urandom),
                  6'($urandom));
      end else if (pick < 22) begin
        cad = (r < 10) ? 16'd0 : (r < 85) ? 16'($urandom_range(1, 40)) : 16'($urandom);
        r = $urandom_range(99);
        secs = (r < 60) ? 23'($urandom_range(1, 3)) : (r < 90) ? 23'd0 : 23'($urandom);
        send_item(ACT_CREATE, clock_ms, cad, 6'($urandom), secs, 6'($urandom));
        sent++;
      end else if (pick < 32) begin
        sel = (r < 85) ? 6'($urandom_range(0, SLOTS)) : 6'($urandom);
        send_item(ACT_REMOVE, $urandom, 16'($urandom), 6'($urandom), 23'($urandom), sel);
        sent++;
      end else begin
        if (r < 80) clock_ms += 32'($urandom_range(0, 25));
        else if (r < 96) clock_ms += 32'($urandom_range(500, 4000));
        else clock_ms = $urandom;
        send_item(ACT_TICK, clock_ms, 16'($urandom), 6'($urandom), 23'($urandom),
                  6'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random_with_gaps();
    gaps_on = 1'b1;
    clock_ms = $urandom;
    run_random_traffic(100);
  endtask

  task automatic test_random_back_to_back();
    gaps_on = 1'b0;
    run_random_traffic(60);
    gaps_on = 1'b1;
  endtask

  // Sender holds off until every pending result is out, then resumes
  task automatic test_drain_pause();
    wait_drained();
    run_random_traffic(40);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) release_channel(i);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_create_and_full();
    test_remove();
    test_tick_edges();
    test_random_with_gaps();
    test_random_back_to_back();
    test_drain_pause();
    wait_drained();
    repeat (SLOTS + 20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pin_events.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
